// ===== hdl/vpit_pkg.sv =====
package vpit_pkg;

    localparam int DEFAULT_MAX_HALF_EXTENT = 50;

    localparam int OFS_W   = 7;
    localparam int EXT_W   = 6;
    localparam int SEL_W   = 3;
    localparam int IDX_W   = 3;
    localparam int MAG_W   = OFS_W;
    localparam int ROOM_W  = OFS_W + 1;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int ESQ_W   = 2 * EXT_W;
    localparam int AC_W    = 2 * ESQ_W;
    localparam int ABC_W   = 3 * ESQ_W;
    localparam int P_W     = SQ_W + ESQ_W;
    localparam int T_W     = P_W + ESQ_W;
    localparam int SUM_W   = T_W + 2;
    localparam int CYL_W   = P_W + 1;
    localparam int PYR_W   = ROOM_W + EXT_W;

    localparam logic [IDX_W-1:0] REG_SHAPE = 3'd0;
    localparam logic [IDX_W-1:0] REG_EXT_X = 3'd1;
    localparam logic [IDX_W-1:0] REG_EXT_Y = 3'd2;
    localparam logic [IDX_W-1:0] REG_EXT_Z = 3'd3;

    localparam logic [EXT_W-1:0] EXT_RESET = 6'd5;

    typedef enum logic [SEL_W-1:0] {
        SHAPE_BOX      = 3'd0,
        SHAPE_SPHERE   = 3'd1,
        SHAPE_CYLINDER = 3'd2,
        SHAPE_PYRAMID  = 3'd3
    } shape_t;

    typedef struct packed {
        logic [SEL_W-1:0] shape;
        logic [EXT_W-1:0] ext_a;
        logic [EXT_W-1:0] ext_b;
        logic [EXT_W-1:0] ext_c;
        logic [ESQ_W-1:0] a2;
        logic [ESQ_W-1:0] b2;
        logic [ESQ_W-1:0] c2;
        logic [AC_W-1:0]  ac2;
        logic [ABC_W-1:0] abc2;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        logic             box_ok;
        logic             cyl_ok;
        logic             pyr_ok;
        logic [T_W-1:0]   s1;
        logic [T_W-1:0]   s2;
        logic [T_W-1:0]   s3;
    } stage_t;

endpackage

// ===== hdl/vpit_cfg.sv =====
module vpit_cfg
    import vpit_pkg::*;
#(
    parameter int MAX_HALF_EXTENT = DEFAULT_MAX_HALF_EXTENT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [IDX_W-1:0]  cfg_wr_index,
    input  logic [EXT_W-1:0]  cfg_wr_data,
    output cfg_t              cfg
);

    function automatic logic [EXT_W-1:0] clamp_ext(input logic [EXT_W-1:0] v);
        if (int'(v) > MAX_HALF_EXTENT) begin
            return EXT_W'(MAX_HALF_EXTENT);
        end
        return v;
    endfunction

    logic [SEL_W-1:0] shape_reg;
    logic [EXT_W-1:0] ext_a_reg, ext_b_reg, ext_c_reg;
    logic [ESQ_W-1:0] a2_reg, b2_reg, c2_reg;
    logic [AC_W-1:0]  ac2_reg;
    logic [ABC_W-1:0] abc2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shape_reg <= SHAPE_BOX;
            ext_a_reg <= clamp_ext(EXT_RESET);
            ext_b_reg <= clamp_ext(EXT_RESET);
            ext_c_reg <= clamp_ext(EXT_RESET);
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_SHAPE: shape_reg <= cfg_wr_data[SEL_W-1:0];
                REG_EXT_X: ext_a_reg <= clamp_ext(cfg_wr_data);
                REG_EXT_Y: ext_b_reg <= clamp_ext(cfg_wr_data);
                REG_EXT_Z: ext_c_reg <= clamp_ext(cfg_wr_data);
                default: ;
            endcase
        end
    end

    // derived squares, then the products ac2 and abc2, are registered in turn after a write
    always_ff @(posedge aclk) begin
        a2_reg   <= ESQ_W'(ext_a_reg) * ESQ_W'(ext_a_reg);
        b2_reg   <= ESQ_W'(ext_b_reg) * ESQ_W'(ext_b_reg);
        c2_reg   <= ESQ_W'(ext_c_reg) * ESQ_W'(ext_c_reg);
        ac2_reg  <= AC_W'(a2_reg) * AC_W'(c2_reg);
        abc2_reg <= ABC_W'(ac2_reg) * ABC_W'(b2_reg);
    end

    assign cfg.shape = shape_reg;
    assign cfg.ext_a = ext_a_reg;
    assign cfg.ext_b = ext_b_reg;
    assign cfg.ext_c = ext_c_reg;
    assign cfg.a2    = a2_reg;
    assign cfg.b2    = b2_reg;
    assign cfg.c2    = c2_reg;
    assign cfg.ac2   = ac2_reg;
    assign cfg.abc2  = abc2_reg;

endmodule

// ===== hdl/vpit_pipe.sv =====
module vpit_pipe
    import vpit_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    adv,
    input  logic                    in_valid,
    input  logic signed [OFS_W-1:0] offset_x,
    input  logic signed [OFS_W-1:0] offset_y,
    input  logic signed [OFS_W-1:0] offset_z,
    input  cfg_t                    cfg,
    output stage_t                  st
);

    // stage 1: magnitudes, box test, squares
    logic [MAG_W-1:0]  ax, ay, az;
    logic              box_ok;
    logic [ROOM_W-1:0] room;

    assign ax = offset_x[OFS_W-1] ? MAG_W'(-offset_x) : MAG_W'(offset_x);
    assign ay = offset_y[OFS_W-1] ? MAG_W'(-offset_y) : MAG_W'(offset_y);
    assign az = offset_z[OFS_W-1] ? MAG_W'(-offset_z) : MAG_W'(offset_z);
    assign box_ok = (ax <= MAG_W'(cfg.ext_a)) && (ay <= MAG_W'(cfg.ext_b))
                 && (az <= MAG_W'(cfg.ext_c));
    assign room = ROOM_W'(cfg.ext_b) - ROOM_W'(offset_y);

    logic              v1_reg, box1_reg;
    logic [SQ_W-1:0]   ax2_1_reg, ay2_1_reg, az2_1_reg;
    logic [MAG_W-1:0]  ax1_reg, az1_reg;
    logic [ROOM_W-1:0] room1_reg;

    // stage 2
    logic              v2_reg, box2_reg;
    logic [P_W-1:0]    p1_reg, p2_reg, p3_reg, cx_reg;
    logic [PYR_W-1:0]  pl1_reg, pr1_reg, pl2_reg, pr2_reg;

    // stage 3
    logic              v3_reg, box3_reg, cyl3_reg, pyr3_reg;
    logic [T_W-1:0]    s1_reg, s2_reg, s3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            box1_reg  <= box_ok;
            ax2_1_reg <= SQ_W'(ax) * SQ_W'(ax);
            ay2_1_reg <= SQ_W'(ay) * SQ_W'(ay);
            az2_1_reg <= SQ_W'(az) * SQ_W'(az);
            ax1_reg   <= ax;
            az1_reg   <= az;
            room1_reg <= room;

            box2_reg  <= box1_reg;
            p1_reg    <= P_W'(ax2_1_reg) * P_W'(cfg.b2);
            p2_reg    <= P_W'(ay2_1_reg) * P_W'(cfg.a2);
            p3_reg    <= P_W'(az2_1_reg) * P_W'(cfg.a2);
            cx_reg    <= P_W'(ax2_1_reg) * P_W'(cfg.c2);
            pl1_reg   <= (PYR_W'(ax1_reg) * PYR_W'(cfg.ext_b)) << 1;
            pl2_reg   <= (PYR_W'(az1_reg) * PYR_W'(cfg.ext_b)) << 1;
            pr1_reg   <= PYR_W'(room1_reg) * PYR_W'(cfg.ext_a);
            pr2_reg   <= PYR_W'(room1_reg) * PYR_W'(cfg.ext_c);

            box3_reg  <= box2_reg;
            s1_reg    <= T_W'(p1_reg) * T_W'(cfg.c2);
            s2_reg    <= T_W'(p2_reg) * T_W'(cfg.c2);
            s3_reg    <= T_W'(p3_reg) * T_W'(cfg.b2);
            cyl3_reg  <= (CYL_W'(cx_reg) + CYL_W'(p3_reg)) <= CYL_W'(cfg.ac2);
            pyr3_reg  <= (pl1_reg <= pr1_reg) && (pl2_reg <= pr2_reg);
        end
    end

    assign st.valid  = v3_reg;
    assign st.box_ok = box3_reg;
    assign st.cyl_ok = cyl3_reg;
    assign st.pyr_ok = pyr3_reg;
    assign st.s1     = s1_reg;
    assign st.s2     = s2_reg;
    assign st.s3     = s3_reg;

endmodule

// ===== hdl/voxel_primitive_inside_test.sv =====
// Voxel shape membership test. Each beat carries one signed voxel offset and
// returns one is_inside flag for the configured shape (box, ellipsoid,
// elliptic cylinder around y, pyramid with its apex at +y; other codes are
// empty). A new beat is taken every cycle while the pipeline is not held; the
// result passes through the three multiply stages and then the output
// register. Back-pressure on m_ready holds the whole pipeline. Half-extents
// are clamped to MAX_HALF_EXTENT on write; write configuration only while no
// beat is in flight.
module voxel_primitive_inside_test
    import vpit_pkg::*;
#(
    parameter int MAX_HALF_EXTENT = DEFAULT_MAX_HALF_EXTENT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [IDX_W-1:0]        cfg_wr_index,
    input  logic [EXT_W-1:0]        cfg_wr_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [OFS_W-1:0] s_offset_x,
    input  logic signed [OFS_W-1:0] s_offset_y,
    input  logic signed [OFS_W-1:0] s_offset_z,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_is_inside
);

    cfg_t   cfg;
    stage_t st;
    logic   adv;

    vpit_cfg #(
        .MAX_HALF_EXTENT(MAX_HALF_EXTENT)
    ) u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    vpit_pipe u_pipe (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (s_valid),
        .offset_x (s_offset_x),
        .offset_y (s_offset_y),
        .offset_z (s_offset_z),
        .cfg      (cfg),
        .st       (st)
    );

    logic m_valid_reg, m_inside_reg;
    logic sphere_ok, any_zero, ac_zero, inside_next;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    assign any_zero  = (cfg.ext_a == '0) || (cfg.ext_b == '0) || (cfg.ext_c == '0);
    assign ac_zero   = (cfg.ext_a == '0) || (cfg.ext_c == '0);
    assign sphere_ok = (SUM_W'(st.s1) + SUM_W'(st.s2) + SUM_W'(st.s3))
                       <= SUM_W'(cfg.abc2);

    always_comb begin
        case (cfg.shape)
            SHAPE_BOX:      inside_next = 1'b1;
            SHAPE_SPHERE:   inside_next = sphere_ok && !any_zero;
            SHAPE_CYLINDER: inside_next = st.cyl_ok && !ac_zero;
            SHAPE_PYRAMID:  inside_next = st.pyr_ok && !any_zero;
            default:        inside_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= st.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_inside_reg <= st.box_ok && inside_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_is_inside = m_inside_reg;

endmodule

// ===== tb/tb_voxel_primitive_inside_test.sv =====
`timescale 1ns / 100ps

module tb_voxel_primitive_inside_test;
    import vpit_pkg::*;

    localparam int MAX_EXT     = DEFAULT_MAX_HALF_EXTENT;
    localparam int PIPE_DEPTH  = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_PHASES = 18;
    localparam int PHASE_BEATS = 25;

    localparam logic [SEL_W-1:0] SHAPE_ARROW   = 3'd4;
    localparam logic [SEL_W-1:0] SHAPE_HEXAGON = 3'd5;
    localparam logic [SEL_W-1:0] SHAPE_BAR     = 3'd6;
    localparam logic [SEL_W-1:0] SHAPE_SPARE   = 3'd7;

    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd4;

    typedef struct packed {
        logic signed [OFS_W-1:0] x;
        logic signed [OFS_W-1:0] y;
        logic signed [OFS_W-1:0] z;
    } voxel_ofs_t;

    logic                    aclk;
    logic                    aresetn      = 1'b0;
    logic                    cfg_wr_en    = 1'b0;
    logic [IDX_W-1:0]        cfg_wr_index = '0;
    logic [EXT_W-1:0]        cfg_wr_data  = '0;
    logic                    s_valid      = 1'b0;
    logic                    s_ready;
    logic signed [OFS_W-1:0] s_offset_x   = '0;
    logic signed [OFS_W-1:0] s_offset_y   = '0;
    logic signed [OFS_W-1:0] s_offset_z   = '0;
    logic                    m_valid;
    logic                    m_ready      = 1'b0;
    logic                    m_is_inside;

    voxel_ofs_t offset_q[$];
    logic       membership_q[$];
    int         error_count = 0;
    int         cycle_count = 0;
    int         send_gap    = 0;
    int         recv_gap    = 0;
    bit         steady      = 1'b0;

    // shadow of the shape registers
    logic [SEL_W-1:0] sh_shape = SHAPE_BOX;
    logic [EXT_W-1:0] sh_ext_x = EXT_RESET;
    logic [EXT_W-1:0] sh_ext_y = EXT_RESET;
    logic [EXT_W-1:0] sh_ext_z = EXT_RESET;

    voxel_primitive_inside_test dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_offset_x   (s_offset_x),
        .s_offset_y   (s_offset_y),
        .s_offset_z   (s_offset_z),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_is_inside  (m_is_inside)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic voxel_in_shape(voxel_ofs_t v);
        longint a, b, c, x, y, z, ax, ay, az, a2, b2, c2, room;
        a  = (sh_ext_x > MAX_EXT) ? MAX_EXT : sh_ext_x;
        b  = (sh_ext_y > MAX_EXT) ? MAX_EXT : sh_ext_y;
        c  = (sh_ext_z > MAX_EXT) ? MAX_EXT : sh_ext_z;
        x  = $signed(v.x);
        y  = $signed(v.y);
        z  = $signed(v.z);
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        a2 = a * a;
        b2 = b * b;
        c2 = c * c;
        if (ax > a || ay > b || az > c)
            return 1'b0;
        case (sh_shape)
            SHAPE_BOX: return 1'b1;
            SHAPE_SPHERE: begin
                if (a == 0 || b == 0 || c == 0)
                    return 1'b0;
                return ax * ax * b2 * c2 + ay * ay * a2 * c2 + az * az * a2 * b2
                       <= a2 * b2 * c2;
            end
            SHAPE_CYLINDER: begin
                if (a == 0 || c == 0)
                    return 1'b0;
                return ax * ax * c2 + az * az * a2 <= a2 * c2;
            end
            SHAPE_PYRAMID: begin
                if (a == 0 || b == 0 || c == 0)
                    return 1'b0;
                room = b - y;
                return (2 * ax * b <= room * a) && (2 * az * b <= room * c);
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin : drive
            voxel_ofs_t nxt;
            logic       hit;
            if (s_valid && s_ready) begin
                hit = voxel_in_shape('{s_offset_x, s_offset_y, s_offset_z});
                membership_q.insert(membership_q.size(), hit);
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (offset_q.size() > 0) begin
                    nxt         = offset_q.pop_front();
                    s_offset_x <= nxt.x;
                    s_offset_y <= nxt.y;
                    s_offset_z <= nxt.z;
                    s_valid    <= 1'b1;
                    send_gap   <= pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and result-side stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            recv_gap <= 0;
        end else begin : watch
            logic want;
            if (m_valid && m_ready) begin
                if (membership_q.size() == 0) begin
                    $display("%0t: unexpected beat, actual is_inside=%0b", $time, m_is_inside);
                    error_count++;
                end else begin
                    want = membership_q.pop_front();
                    if (m_is_inside !== want) begin
                        $display("%0t: is_inside expected %0b actual %0b",
                                 $time, want, m_is_inside);
                        error_count++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready  <= 1'b0;
            end else begin
                m_ready  <= 1'b1;
                recv_gap <= pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [EXT_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        case (idx)
            REG_SHAPE: sh_shape = data[SEL_W-1:0];
            REG_EXT_X: sh_ext_x = data;
            REG_EXT_Y: sh_ext_y = data;
            REG_EXT_Z: sh_ext_z = data;
            default: ;
        endcase
    endtask

    task automatic program_shape(logic [SEL_W-1:0] shape, logic [EXT_W-1:0] ex,
                                 logic [EXT_W-1:0] ey, logic [EXT_W-1:0] ez, bit junk);
        write_reg(REG_SHAPE, EXT_W'(shape));
        write_reg(REG_EXT_X, ex);
        write_reg(REG_EXT_Y, ey);
        write_reg(REG_EXT_Z, ez);
        if (junk)
            write_reg(REG_SPARE_LO + IDX_W'($urandom_range(0, 3)), EXT_W'($urandom));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send(int x, int y, int z);
        voxel_ofs_t item;
        item = '{OFS_W'(x), OFS_W'(y), OFS_W'(z)};
        offset_q.insert(offset_q.size(), item);
    endtask

    // sender holds off until the pipeline has fully drained
    task automatic drain();
        do
            @(posedge aclk);
        while (offset_q.size() != 0 || s_valid || membership_q.size() != 0);
        repeat (PIPE_DEPTH + 2) @(posedge aclk);
    endtask

    function automatic logic [EXT_W-1:0] pick_ext();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r < 3)
            return EXT_W'(MAX_EXT);
        if (r < 5)
            return EXT_W'($urandom_range(MAX_EXT + 1, (1 << EXT_W) - 1));
        if (r < 12)
            return EXT_W'($urandom_range(1, 8));
        return EXT_W'($urandom_range(1, MAX_EXT));
    endfunction

    function automatic int pick_offset(logic [EXT_W-1:0] e);
        int lim;
        lim = ((e > MAX_EXT) ? MAX_EXT : int'(e)) + 1;
        if ($urandom_range(0, 9) < 8)
            return int'($urandom_range(0, 2 * lim)) - lim;
        return $urandom_range(0, (1 << OFS_W) - 1);
    endfunction

    initial begin
        logic [SEL_W-1:0] shp;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset configuration: box of half size 5
        send(0, 0, 0);
        send(5, -5, 5);
        send(6, 0, 0);
        send(-64, 63, 0);
        send(-5, 5, -6);
        drain();

        program_shape(SHAPE_BOX, 0, 0, 0, 1'b0);
        send(0, 0, 0);
        send(1, 0, 0);
        drain();

        program_shape(SHAPE_SPHERE, 63, 63, 63, 1'b1);
        send(50, 0, 0);
        send(36, 36, 0);
        send(0, -50, 0);
        send(-50, 50, 50);
        drain();

        program_shape(SHAPE_SPHERE, 3, 0, 4, 1'b0);
        send(0, 0, 0);
        drain();

        program_shape(SHAPE_CYLINDER, 4, 9, 3, 1'b0);
        send(4, 9, 0);
        send(-2, -9, 2);
        send(0, 10, 0);
        drain();

        program_shape(SHAPE_CYLINDER, 0, 5, 3, 1'b0);
        send(0, 0, 0);
        drain();

        program_shape(SHAPE_PYRAMID, 5, 5, 5, 1'b0);
        send(5, -5, 5);
        send(0, 5, 0);
        send(1, 5, 0);
        send(3, 0, 2);
        drain();

        program_shape(SHAPE_PYRAMID, 5, 0, 5, 1'b0);
        send(0, 0, 0);
        drain();

        program_shape(SHAPE_ARROW, 5, 5, 5, 1'b0);
        send(0, 0, 0);
        drain();
        program_shape(SHAPE_HEXAGON, 5, 5, 5, 1'b0);
        send(0, 0, 0);
        drain();
        program_shape(SHAPE_BAR, 5, 5, 5, 1'b0);
        send(0, 0, 0);
        drain();
        program_shape(SHAPE_SPARE, 5, 5, 5, 1'b1);
        send(0, 0, 0);
        drain();

        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p < 8)
                shp = SEL_W'(p);
            else if ($urandom_range(0, 3) == 0)
                shp = SEL_W'($urandom_range(0, 7));
            else
                shp = SEL_W'($urandom_range(0, 3));
            program_shape(shp, pick_ext(), pick_ext(), pick_ext(), $urandom_range(0, 2) == 0);
            steady = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_BEATS; i++)
                send(pick_offset(sh_ext_x), pick_offset(sh_ext_y), pick_offset(sh_ext_z));
            drain();
        end

        repeat (4 * PIPE_DEPTH) @(posedge aclk);
        if (membership_q.size() != 0) begin
            $display("%0t: %0d results missing", $time, membership_q.size());
            error_count++;
        end
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
